[rtl/smd_pkg.sv]
package smd_pkg;

	// Default length of the boxcar average window.
	localparam int AVG_LEN_DEF = 8;

	// Operation codes carried by an input beat.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_IGNORE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_MIN_WIDTH = 2'd1;
	localparam logic [1:0] CFG_IGNORE    = 2'd2;

	// Reset value of the threshold configuration register.
	localparam logic [15:0] THRESHOLD_RST = 16'hFFFF;

	// Marker tracking states, coded as reported on marker_state.
	typedef enum logic [1:0] {
		ST_IGNORING = 2'd0,
		ST_WAITING  = 2'd1,
		ST_PASSING  = 2'd2,
		ST_PASSED   = 2'd3
	} marker_state_t;

	// Per-beat commands from the input stage to the datapath blocks.
	typedef struct packed {
		logic push;
		logic set_ignore;
		logic clear;
	} step_ctrl_t;

endpackage

[rtl/smd_averager.sv]
module smd_averager #(
	parameter int AVG_LEN = smd_pkg::AVG_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smd_pkg::step_ctrl_t ctrl,
	input  logic [15:0]         sample,
	output logic [15:0]         avg_d
);

	localparam int SUM_W = 16 + $clog2(AVG_LEN);
	localparam int SHIFT = $clog2(AVG_LEN + 1) - 1;

	logic [15:0]      taps_q [AVG_LEN];
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_d;
	logic [SUM_W-1:0] shifted;

	// Next window sum: drop the oldest tap, add the new sample; zero on a clear.
	always_comb begin
		sum_d = sum_q;
		if (ctrl.clear) begin
			sum_d = '0;
		end else if (ctrl.push) begin
			sum_d = sum_q - SUM_W'(taps_q[AVG_LEN-1]) + SUM_W'(sample);
		end
	end

	// Average after this beat, saturated to 16 bits.
	always_comb begin
		shifted = sum_d >> SHIFT;
		if (shifted > SUM_W'(16'hFFFF)) begin
			avg_d = 16'hFFFF;
		end else begin
			avg_d = shifted[15:0];
		end
	end

	// Sample window as a shift line; the last tap is the oldest sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < AVG_LEN; i++) begin
				taps_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			sum_q <= '0;
			for (int i = 0; i < AVG_LEN; i++) begin
				taps_q[i] <= '0;
			end
		end else if (ctrl.push) begin
			sum_q     <= sum_d;
			taps_q[0] <= sample;
			for (int i = 1; i < AVG_LEN; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

endmodule

[rtl/smd_tracker.sv]
module smd_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smd_pkg::step_ctrl_t    ctrl,
	input  logic signed [31:0]     distance,
	input  logic [15:0]            avg_d,
	input  logic [15:0]            detect_threshold,
	input  logic [30:0]            min_marker_width,
	input  logic [30:0]            ignore_span,
	output smd_pkg::marker_state_t state_d,
	output logic [15:0]            count_d,
	output logic signed [31:0]     start_d
);

	smd_pkg::marker_state_t state_q;
	logic [15:0]            count_q;
	logic signed [31:0]     start_q;
	logic signed [31:0]     origin_q;
	logic signed [31:0]     origin_d;
	logic                   seen;
	logic                   past_ignore;
	logic                   too_narrow;

	// Magnitude of a 33-bit difference of two signed 32-bit distances.
	function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	assign seen        = avg_d > detect_threshold;
	assign past_ignore = abs_diff(distance, origin_q) > {2'b00, ignore_span};
	assign too_narrow  = abs_diff(distance, start_q) < {2'b00, min_marker_width};

	// Next state.
	always_comb begin
		state_d = state_q;
		if (ctrl.clear) begin
			state_d = smd_pkg::ST_WAITING;
		end else if (ctrl.set_ignore) begin
			state_d = smd_pkg::ST_IGNORING;
		end else if (ctrl.push) begin
			case (state_q)
				smd_pkg::ST_IGNORING: begin
					if (past_ignore) state_d = smd_pkg::ST_WAITING;
				end
				smd_pkg::ST_WAITING: begin
					if (seen) state_d = smd_pkg::ST_PASSING;
				end
				smd_pkg::ST_PASSING: begin
					if (!seen) begin
						state_d = too_narrow ? smd_pkg::ST_WAITING : smd_pkg::ST_PASSED;
					end
				end
				default: begin
					state_d = smd_pkg::ST_WAITING;
				end
			endcase
		end
	end

	// Marker start, ignore origin and saturating pass count.
	always_comb begin
		count_d  = count_q;
		start_d  = start_q;
		origin_d = origin_q;
		if (ctrl.clear) begin
			count_d  = '0;
			start_d  = '0;
			origin_d = '0;
		end else if (ctrl.set_ignore) begin
			origin_d = distance;
		end else if (ctrl.push) begin
			case (state_q)
				smd_pkg::ST_WAITING: begin
					if (seen) start_d = distance;
				end
				smd_pkg::ST_PASSING: begin
					if (!seen && !too_narrow && count_q != 16'hFFFF) begin
						count_d = count_q + 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= smd_pkg::ST_WAITING;
			count_q  <= '0;
			start_q  <= '0;
			origin_q <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			start_q  <= start_d;
			origin_q <= origin_d;
		end
	end

endmodule

[rtl/side_marker_detector.sv]
// Side marker detector. Each input beat carries one operation (sample, start
// ignoring, clear) and is answered by exactly one result beat that shows the
// detector state after that operation. The block takes one beat per clock
// cycle while the output side does not stall. A result beat passes through the
// input register and then the result register before it is presented. The
// rate is set by the combinational window sum update and state step that sit
// between the input register and the result register. Configuration is written
// through the cfg port, which is always ready, and must only be written while no
// beat is in flight.
module side_marker_detector #(
	parameter int AVG_LEN = smd_pkg::AVG_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [15:0]        adc_sample,
	input  logic signed [31:0] distance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         marker_state,
	output logic [15:0]        pass_count,
	output logic signed [31:0] detect_position,
	output logic [15:0]        average_level,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [15:0]            threshold_q;
	logic [30:0]            min_width_q;
	logic [30:0]            ignore_span_q;
	logic                   valid_s1;
	logic [1:0]             op_s1;
	logic [15:0]            adc_s1;
	logic signed [31:0]     dist_s1;
	logic                   valid_s2;
	logic [1:0]             state_s2;
	logic [15:0]            count_s2;
	logic signed [31:0]     start_s2;
	logic [15:0]            avg_s2;
	logic                   out_ready;
	logic                   s1_fire;
	smd_pkg::step_ctrl_t    ctrl;
	logic [15:0]            avg_d;
	smd_pkg::marker_state_t state_d;
	logic [15:0]            count_d;
	logic signed [31:0]     start_d;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= smd_pkg::THRESHOLD_RST;
			min_width_q   <= '0;
			ignore_span_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				smd_pkg::CFG_THRESHOLD: threshold_q   <= cfg_data[15:0];
				smd_pkg::CFG_MIN_WIDTH: min_width_q   <= cfg_data[30:0];
				smd_pkg::CFG_IGNORE:    ignore_span_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the result register frees when empty or being taken.
	assign out_ready = !valid_s2 || !out_stall;
	assign s1_fire   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			adc_s1 <= adc_sample;
			dist_s1 <= distance;
		end
	end

	// Decode the registered beat into commands.
	always_comb begin
		ctrl.push       = s1_fire && (op_s1 == smd_pkg::OP_SAMPLE);
		ctrl.set_ignore = s1_fire && (op_s1 == smd_pkg::OP_IGNORE);
		ctrl.clear      = s1_fire && (op_s1 == smd_pkg::OP_CLEAR);
	end

	smd_averager #(
		.AVG_LEN(AVG_LEN)
	) u_averager (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.sample(adc_s1),
		.avg_d (avg_d)
	);

	smd_tracker u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.distance        (dist_s1),
		.avg_d           (avg_d),
		.detect_threshold(threshold_q),
		.min_marker_width(min_width_q),
		.ignore_span     (ignore_span_q),
		.state_d         (state_d),
		.count_d         (count_d),
		.start_d         (start_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			state_s2 <= state_d;
			count_s2 <= count_d;
			start_s2 <= start_d;
			avg_s2   <= avg_d;
		end
	end

	assign out_valid       = valid_s2;
	assign marker_state    = state_s2;
	assign pass_count      = count_s2;
	assign detect_position = start_s2;
	assign average_level   = avg_s2;

	// A clear beat reports an empty detector.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 == smd_pkg::OP_CLEAR) |=>
		(out_valid && pass_count == 16'd0 && average_level == 16'd0 &&
		marker_state == smd_pkg::ST_WAITING))
		else $error("clear beat did not report an empty detector");

	// A set-ignore beat always reports the ignoring state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 == smd_pkg::OP_IGNORE) |=>
		(out_valid && marker_state == smd_pkg::ST_IGNORING))
		else $error("set-ignore beat did not enter ignoring");

	// The input side only stalls while the input register holds a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	// A sample beat never makes the pass count fall.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 == smd_pkg::OP_SAMPLE) |-> (count_d >= u_tracker.count_q))
		else $error("pass count decreased on a sample beat");

endmodule
